FILE: sv/ffn_pkg.sv
// ----------------------------------------------------------------------------
// ffn_pkg
// Shared types and constants for the flat-field gain map core.
// ----------------------------------------------------------------------------
package ffn_pkg;

	localparam int MAX_DIM_DEF        = 256;
	localparam int INTENSITY_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF      = 16;

	localparam int IN_W       = 24;
	localparam int OUT_W      = 24;
	localparam int MEAN_W     = 32;
	localparam int DIM_REG_W  = 9;
	localparam int CUT_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CUT_LEFT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CUT_RIGHT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CUT_TOP      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CUT_BOTTOM   = 3'd5;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EMIT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_RCDIV,
		ST_SWEEP,
		ST_SWDRAIN,
		ST_MSTART,
		ST_MDIV,
		ST_FREAD,
		ST_FCHK,
		ST_FDIV
	} state_t;

	typedef enum logic [1:0] {
		DV_RC,
		DV_MEAN,
		DV_FAC
	} div_op_t;

endpackage

FILE: sv/ffn_ram.sv
// ----------------------------------------------------------------------------
// ffn_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module ffn_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/flat_field_normalizer_core.sv
// ----------------------------------------------------------------------------
// flat_field_normalizer_core
// Flat-field gain map: stores a correction image, takes the mean over a
// trimmed rectangle and returns one Q8.16 gain factor per pixel.
// ----------------------------------------------------------------------------
// Usage: a word is taken at a clock edge with start high and busy low.
// func = 0 writes intensity into the next raster position of the store and
// busy stays low. func = 1 asks for the next gain factor;
// busy stays high until the result is out, and done pulses for one cycle with
// gain_factor, factor_valid and last_pixel. The receiver cannot stall.
// A pixel outside the rectangle, of zero intensity or with a saturated factor
// gets its gain without a division; inside it the factor comes from the
// shared radix-2 divider that retires one quotient bit per cycle. The
// first request of a pass also sweeps the rectangle, if it is not empty,
// through the store read port, one pixel per cycle, then divides the sum by
// the pixel count. The first request after image_width is rewritten also
// splits the position into row and column on the same divider.
// Config writes are taken at any edge with cfg_we high; busy is high for the
// cycle after one. Reset clears indexes, sum and mean, sets the config to
// 256 x 256 with no cuts and leaves the pixel store undefined until loaded.
// ----------------------------------------------------------------------------
module flat_field_normalizer_core
	import ffn_pkg::*;
#(
	parameter int MAX_DIM        = MAX_DIM_DEF,
	parameter int INTENSITY_BITS = INTENSITY_BITS_DEF,
	parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  logic                  func,
	input  logic [IN_W-1:0]       intensity,
	output logic                  done,
	output logic [OUT_W-1:0]      gain_factor,
	output logic                  factor_valid,
	output logic                  last_pixel
);

	localparam int RC_W      = $clog2(MAX_DIM);
	localparam int DIM_W     = $clog2(MAX_DIM + 1);
	localparam int ADDR_W    = 2 * RC_W;
	localparam int AREA_W    = ADDR_W + 1;
	localparam int DEPTH     = 2 ** ADDR_W;
	localparam int STORE_W   = (INTENSITY_BITS < IN_W) ? INTENSITY_BITS : IN_W;
	localparam int MEAN_FRAC = MEAN_W - INTENSITY_BITS;
	localparam int SUM_W     = STORE_W + ADDR_W;
	localparam int E_W       = ((DIM_W > CUT_W + 1) ? DIM_W : CUT_W + 1) + 1;
	localparam int FDVS_W    = STORE_W + MEAN_FRAC;
	localparam int R_W       = (AREA_W > FDVS_W) ? AREA_W : FDVS_W;
	localparam int Q_W       = MEAN_W;
	localparam int DCNT_W    = $clog2(Q_W + 1);
	localparam int MDVD_W    = SUM_W + MEAN_FRAC;
	localparam int FDVD_W    = MEAN_W + FRAC_BITS;
	localparam int DVD_A     = (MDVD_W > FDVD_W) ? MDVD_W : FDVD_W;
	localparam int DVD_W     = (DVD_A > ADDR_W) ? DVD_A : ADDR_W;
	localparam int SATR_W    = FDVS_W + OUT_W;
	localparam int SAT_W     = (FDVD_W > SATR_W) ? FDVD_W : SATR_W;

	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
	localparam logic [OUT_W-1:0] ONE_VAL =
		(FRAC_BITS >= OUT_W) ? OUT_MAX : OUT_W'(64'd1 << FRAC_BITS);

	// configuration registers
	logic [DIM_REG_W-1:0] image_width_q, image_height_q;
	logic [CUT_W-1:0]     cut_left_q, cut_right_q, cut_top_q, cut_bottom_q;
	logic                 settle_q;

	// derived geometry
	logic [DIM_W-1:0]  w_c, h_c;
	logic [E_W-1:0]    rw_c, rh_c;
	logic [DIM_W-1:0]  w_q;
	logic [AREA_W-1:0] area_q, count_q;
	logic [ADDR_W-1:0] base0_q;
	logic [RC_W-1:0]   col_hi_q, row_hi_q, wlast_q;
	logic              empty_q;

	// sequencer and datapath
	state_t            state_q, state_d;
	logic [ADDR_W-1:0] load_q, emit_q;
	logic [RC_W-1:0]   row_q, col_q;
	logic              stale_q;
	logic [SUM_W-1:0]  region_sum_q;
	logic [MEAN_W-1:0] region_mean_q;
	logic [RC_W-1:0]   sw_row_q, sw_col_q;
	logic [ADDR_W-1:0] sw_base_q;
	logic              acc_v_s1;
	logic              done_q, valid_q, last_q;
	logic [OUT_W-1:0]  gain_q;

	// shared divider
	logic [R_W-1:0]    div_rem_q, div_dvs_q;
	logic [Q_W-1:0]    div_quo_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic [R_W+1:0]    div_trial;
	logic              div_busy;
	logic              div_ld;
	div_op_t           div_op;
	logic [R_W-1:0]    ld_rem, ld_dvs;
	logic [Q_W-1:0]    ld_quo;
	logic [DCNT_W-1:0] ld_cnt;
	logic [DVD_W-1:0]  mdvd, fdvd;

	// misc
	logic              accept, e_wrap, emit_go, sat, in_rect, sw_last;
	logic [AREA_W-1:0] load_nxt, emit_nxt;
	logic [ADDR_W-1:0] load_addr, rd_addr;
	logic [STORE_W-1:0] rd_data;
	logic [SAT_W-1:0]  sat_num, sat_den;
	logic [OUT_W-1:0]  res_gain;
	logic              res_valid;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_REG_W'(256);
			image_height_q <= DIM_REG_W'(256);
			cut_left_q     <= '0;
			cut_right_q    <= '0;
			cut_top_q      <= '0;
			cut_bottom_q   <= '0;
			settle_q       <= 1'b1;
		end else begin
			settle_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
					REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
					REG_CUT_LEFT:     cut_left_q     <= cfg_data[CUT_W-1:0];
					REG_CUT_RIGHT:    cut_right_q    <= cfg_data[CUT_W-1:0];
					REG_CUT_TOP:      cut_top_q      <= cfg_data[CUT_W-1:0];
					REG_CUT_BOTTOM:   cut_bottom_q   <= cfg_data[CUT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		if (image_width_q == '0) begin
			w_c = DIM_W'(1);
		end else if (32'(image_width_q) > MAX_DIM) begin
			w_c = DIM_W'(MAX_DIM);
		end else begin
			w_c = DIM_W'(image_width_q);
		end
		if (image_height_q == '0) begin
			h_c = DIM_W'(1);
		end else if (32'(image_height_q) > MAX_DIM) begin
			h_c = DIM_W'(MAX_DIM);
		end else begin
			h_c = DIM_W'(image_height_q);
		end
		rw_c = E_W'(w_c) - E_W'(cut_left_q) - E_W'(cut_right_q);
		rh_c = E_W'(h_c) - E_W'(cut_top_q) - E_W'(cut_bottom_q);
	end

	always_ff @(posedge clk) begin
		w_q      <= w_c;
		area_q   <= AREA_W'(w_c) * AREA_W'(h_c);
		count_q  <= AREA_W'(DIM_W'(rw_c)) * AREA_W'(DIM_W'(rh_c));
		base0_q  <= ADDR_W'(AREA_W'(cut_top_q) * AREA_W'(w_c));
		col_hi_q <= RC_W'(E_W'(w_c) - E_W'(cut_right_q) - E_W'(1));
		row_hi_q <= RC_W'(E_W'(h_c) - E_W'(cut_bottom_q) - E_W'(1));
		wlast_q  <= RC_W'(w_c - DIM_W'(1));
		empty_q  <= (E_W'(cut_left_q) + E_W'(cut_right_q) >= E_W'(w_c)) ||
			(E_W'(cut_top_q) + E_W'(cut_bottom_q) >= E_W'(h_c));
	end

	// ---------------- pixel store ----------------
	assign accept    = start && !busy;
	assign load_addr = ({1'b0, load_q} >= area_q) ? '0 : load_q;
	assign load_nxt  = {1'b0, load_addr} + AREA_W'(1);
	assign rd_addr   = (state_q == ST_SWEEP) ? sw_base_q + ADDR_W'(sw_col_q) : emit_q;

	ffn_ram #(
		.WIDTH(STORE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept && (func == FUNC_LOAD)),
		.waddr (load_addr),
		.wdata (intensity[STORE_W-1:0]),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// ---------------- shared divider ----------------
	assign div_trial = {1'b0, div_rem_q, div_quo_q[Q_W-1]} - {2'b00, div_dvs_q};
	assign div_busy  = (div_cnt_q != '0);
	assign mdvd      = DVD_W'(region_sum_q) << MEAN_FRAC;
	assign fdvd      = DVD_W'(region_mean_q) << FRAC_BITS;

	always_comb begin
		case (div_op)
			DV_RC: begin
				ld_rem = R_W'(emit_q >> RC_W);
				ld_quo = {emit_q[RC_W-1:0], {(Q_W-RC_W){1'b0}}};
				ld_dvs = R_W'(w_q);
				ld_cnt = DCNT_W'(RC_W);
			end
			DV_MEAN: begin
				ld_rem = R_W'(mdvd >> Q_W);
				ld_quo = mdvd[Q_W-1:0];
				ld_dvs = R_W'(count_q);
				ld_cnt = DCNT_W'(Q_W);
			end
			DV_FAC: begin
				ld_rem = R_W'(fdvd >> OUT_W);
				ld_quo = {fdvd[OUT_W-1:0], {(Q_W-OUT_W){1'b0}}};
				ld_dvs = R_W'(rd_data) << MEAN_FRAC;
				ld_cnt = DCNT_W'(OUT_W);
			end
			default: begin
				ld_rem = '0;
				ld_quo = '0;
				ld_dvs = '0;
				ld_cnt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (div_ld) begin
			div_cnt_q <= ld_cnt;
		end else if (div_busy) begin
			div_cnt_q <= div_cnt_q - DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (div_ld) begin
			div_rem_q <= ld_rem;
			div_quo_q <= ld_quo;
			div_dvs_q <= ld_dvs;
		end else if (div_busy) begin
			if (!div_trial[R_W+1]) begin
				div_rem_q <= div_trial[R_W-1:0];
				div_quo_q <= {div_quo_q[Q_W-2:0], 1'b1};
			end else begin
				div_rem_q <= {div_rem_q[R_W-2:0], div_quo_q[Q_W-1]};
				div_quo_q <= {div_quo_q[Q_W-2:0], 1'b0};
			end
		end
	end

	// ---------------- factor decision ----------------
	assign e_wrap   = ({1'b0, emit_q} >= area_q);
	assign emit_nxt = {1'b0, emit_q} + AREA_W'(1);
	assign sw_last  = (sw_row_q == row_hi_q) && (sw_col_q == col_hi_q);
	assign in_rect  = !empty_q &&
		(E_W'(col_q) >= E_W'(cut_left_q)) && (col_q <= col_hi_q) &&
		(E_W'(row_q) >= E_W'(cut_top_q)) && (row_q <= row_hi_q);
	assign sat_num  = SAT_W'(region_mean_q) << FRAC_BITS;
	assign sat_den  = SAT_W'(rd_data) << (MEAN_FRAC + OUT_W);
	assign sat      = (sat_num >= sat_den);

	always_comb begin
		if (state_q == ST_FDIV) begin
			res_gain  = div_quo_q[OUT_W-1:0];
			res_valid = 1'b1;
		end else if (!in_rect) begin
			res_gain  = ONE_VAL;
			res_valid = 1'b1;
		end else if (rd_data == '0) begin
			res_gain  = '0;
			res_valid = 1'b0;
		end else begin
			res_gain  = OUT_MAX;
			res_valid = 1'b1;
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		div_ld  = 1'b0;
		div_op  = DV_RC;
		emit_go = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (func == FUNC_EMIT)) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (stale_q) begin
					div_ld  = 1'b1;
					div_op  = DV_RC;
					state_d = ST_RCDIV;
				end else if (emit_q == '0 && !empty_q) begin
					state_d = ST_SWEEP;
				end else begin
					state_d = ST_FREAD;
				end
			end
			ST_RCDIV: begin
				if (!div_busy) begin
					state_d = ST_PREP;
				end
			end
			ST_SWEEP: begin
				if (sw_last) begin
					state_d = ST_SWDRAIN;
				end
			end
			ST_SWDRAIN: begin
				state_d = ST_MSTART;
			end
			ST_MSTART: begin
				div_ld  = 1'b1;
				div_op  = DV_MEAN;
				state_d = ST_MDIV;
			end
			ST_MDIV: begin
				if (!div_busy) begin
					state_d = ST_FREAD;
				end
			end
			ST_FREAD: begin
				state_d = ST_FCHK;
			end
			ST_FCHK: begin
				if (in_rect && rd_data != '0 && !sat) begin
					div_ld  = 1'b1;
					div_op  = DV_FAC;
					state_d = ST_FDIV;
				end else begin
					emit_go = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_FDIV: begin
				div_op = DV_FAC;
				if (!div_busy) begin
					emit_go = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------- indexes, sum, mean ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q        <= '0;
			emit_q        <= '0;
			row_q         <= '0;
			col_q         <= '0;
			stale_q       <= 1'b0;
			region_sum_q  <= '0;
			region_mean_q <= '0;
			acc_v_s1      <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			acc_v_s1 <= (state_q == ST_SWEEP);
			done_q   <= emit_go;
			if (accept && (func == FUNC_LOAD)) begin
				load_q  <= (load_nxt >= area_q) ? '0 : load_nxt[ADDR_W-1:0];
				emit_q  <= '0;
				row_q   <= '0;
				col_q   <= '0;
				stale_q <= 1'b0;
			end else if (accept && e_wrap) begin
				emit_q  <= '0;
				row_q   <= '0;
				col_q   <= '0;
				stale_q <= 1'b0;
			end
			if (state_q == ST_PREP && !stale_q && emit_q == '0) begin
				region_sum_q  <= '0;
				region_mean_q <= '0;
			end
			if (state_q == ST_RCDIV && !div_busy) begin
				row_q   <= div_quo_q[RC_W-1:0];
				col_q   <= div_rem_q[RC_W-1:0];
				stale_q <= 1'b0;
			end
			if (acc_v_s1) begin
				region_sum_q <= region_sum_q + SUM_W'(rd_data);
			end
			if (state_q == ST_MDIV && !div_busy) begin
				region_mean_q <= div_quo_q;
			end
			if (emit_go) begin
				if (emit_nxt >= area_q) begin
					emit_q <= '0;
					row_q  <= '0;
					col_q  <= '0;
				end else begin
					emit_q <= emit_nxt[ADDR_W-1:0];
					if (col_q == wlast_q) begin
						col_q <= '0;
						row_q <= row_q + RC_W'(1);
					end else begin
						col_q <= col_q + RC_W'(1);
					end
				end
			end
			if (cfg_we && cfg_index == REG_IMAGE_WIDTH) begin
				stale_q <= 1'b1;
			end
		end
	end

	// sweep walker and result word
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			sw_row_q  <= RC_W'(cut_top_q);
			sw_col_q  <= RC_W'(cut_left_q);
			sw_base_q <= base0_q;
		end else if (state_q == ST_SWEEP) begin
			if (sw_col_q == col_hi_q) begin
				sw_col_q  <= RC_W'(cut_left_q);
				sw_row_q  <= sw_row_q + RC_W'(1);
				sw_base_q <= sw_base_q + ADDR_W'(w_q);
			end else begin
				sw_col_q <= sw_col_q + RC_W'(1);
			end
		end
		if (emit_go) begin
			gain_q  <= res_gain;
			valid_q <= res_valid;
			last_q  <= ({1'b0, emit_q} == area_q - AREA_W'(1));
		end
	end

	assign busy         = (state_q != ST_IDLE) || settle_q;
	assign done         = done_q;
	assign gain_factor  = gain_q;
	assign factor_valid = valid_q;
	assign last_pixel   = last_q;

endmodule
